/* design/olirf_pkg.sv */
// Shared types and constants for the ordered list unit.
`timescale 1ns / 1ps
package olirf_pkg;

  // List capacity and the widths that follow from it
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  // Operation codes; the fourth code is unused and fails
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2
  } op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_FIND,
    ST_PUT,
    ST_DONE
  } state_e;

  // Memory access issued by the sequencer
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

  // One result item
  typedef struct packed {
    logic             status;
    logic [IDX_W-1:0] where;
    logic [CNT_W-1:0] count;
  } res_t;

endpackage

/* design/olirf_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps
module olirf_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/olirf_seq.sv */
// Sequencer: checks each request, then streams shifts or searches through the RAM.
`timescale 1ns / 1ps
module olirf_seq import olirf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic [1:0]        operation_i,
  input  logic [CNT_W-1:0]  position_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic [DATA_W-1:0] key_i,
  output ram_req_t          mem_o,
  input  logic [DATA_W-1:0] rdata_i,
  input  logic              slot_free_i,
  output logic              done_o,
  output res_t              res_o
);

  state_e            state_q, state_d;
  op_e               op_q;
  logic [IDX_W-1:0]  pos_q;
  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] key_q;
  logic [CNT_W-1:0]  count_q;
  logic [IDX_W-1:0]  ptr_q;
  logic [CNT_W-1:0]  left_q;
  logic              pend_q;
  logic [IDX_W-1:0]  pend_addr_q;
  logic              status_q;
  logic [IDX_W-1:0]  where_q;

  logic accept;
  logic ins_ok;
  logic rem_ok;
  logic step_rd;
  logic match;

  assign accept  = req_valid_i && (state_q == ST_IDLE);
  assign ins_ok  = (count_q < CNT_W'(CAPACITY)) && (position_i <= count_q);
  assign rem_ok  = position_i < count_q;
  assign step_rd = ((state_q == ST_SHIFT) || (state_q == ST_FIND)) && (left_q != '0);
  assign match   = (state_q == ST_FIND) && pend_q && (rdata_i == key_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          unique case (operation_i)
            OP_INSERT: state_d = ins_ok ? ST_SHIFT : ST_DONE;
            OP_REMOVE: state_d = rem_ok ? ST_SHIFT : ST_DONE;
            OP_FIND:   state_d = ST_FIND;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_SHIFT: begin
        // last pending write lands in this same cycle
        if (left_q == '0) begin
          state_d = (op_q == OP_INSERT) ? ST_PUT : ST_DONE;
        end
      end
      ST_FIND: begin
        if (match || ((left_q == '0) && !pend_q)) begin
          state_d = ST_DONE;
        end
      end
      ST_PUT:  state_d = ST_DONE;
      ST_DONE: begin
        if (slot_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: RAM access and handshake
  always_comb begin
    req_ready_o = 1'b0;
    done_o      = 1'b0;
    mem_o.raddr = ptr_q;
    mem_o.we    = 1'b0;
    mem_o.waddr = (op_q == OP_INSERT) ? pend_addr_q + 1'b1 : pend_addr_q - 1'b1;
    mem_o.wdata = rdata_i;
    unique case (state_q)
      ST_IDLE:  req_ready_o = 1'b1;
      ST_SHIFT: mem_o.we = pend_q;
      ST_FIND:  mem_o.we = 1'b0;
      ST_PUT: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = pos_q;
        mem_o.wdata = val_q;
      end
      ST_DONE:  done_o = slot_free_i;
      default:  req_ready_o = 1'b0;
    endcase
  end

  assign res_o.status = status_q;
  assign res_o.where  = where_q;
  assign res_o.count  = count_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      left_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= step_rd;
      if (step_rd) begin
        left_q <= left_q - 1'b1;
      end
      if (accept) begin
        unique case (operation_i)
          OP_INSERT: begin
            if (ins_ok) begin
              count_q <= count_q + 1'b1;
              left_q  <= count_q - position_i;
            end
          end
          OP_REMOVE: begin
            if (rem_ok) begin
              count_q <= count_q - 1'b1;
              left_q  <= count_q - position_i - 1'b1;
            end
          end
          OP_FIND:   left_q <= count_q;
          default:   left_q <= '0;
        endcase
      end
    end
  end

  // Request and stream payload
  always_ff @(posedge clk_i) begin
    if (step_rd) begin
      ptr_q <= (op_q == OP_INSERT) ? ptr_q - 1'b1 : ptr_q + 1'b1;
    end
    pend_addr_q <= ptr_q;
    if (match) begin
      status_q <= 1'b0;
      where_q  <= pend_addr_q;
    end
    if (accept) begin
      op_q     <= op_e'(operation_i);
      pos_q    <= position_i[IDX_W-1:0];
      val_q    <= value_i;
      key_q    <= key_i;
      where_q  <= '0;
      // insert and remove succeed when their checks pass; find clears on a match
      unique case (operation_i)
        OP_INSERT: status_q <= !ins_ok;
        OP_REMOVE: status_q <= !rem_ok;
        default:   status_q <= 1'b1;
      endcase
      // insert walks down from the top entry, remove and find walk up
      unique case (operation_i)
        OP_INSERT: ptr_q <= IDX_W'(count_q - 1'b1);
        OP_REMOVE: ptr_q <= IDX_W'(position_i + 1'b1);
        default:   ptr_q <= '0;
      endcase
    end
  end

endmodule

/* design/ordered_list_insert_remove_find_unit.sv */
// Top level of the ordered list unit: sequencer, entry RAM and result register.
//
//   channel  direction  handshake            payload
//   in       input      in_valid_i/ready_o   operation_i, position_i, value_i, key_i
//   out      output     out_valid_o/ready_i  status_o, found_position_o, count_after_o
//
// One request at a time. The entry RAM has one read and one write port and the
// sequencer moves or compares one entry per cycle. Insert at p shifts the entries from p
// up, remove at p shifts those above p down, find scans from the head to the first match.
// A new request is taken while a finished result still waits in the output register.
// Reset clears the count and the control state; the RAM is not cleared.
`timescale 1ns / 1ps
module ordered_list_insert_remove_find_unit import olirf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  input  logic [CNT_W-1:0]  position_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic [DATA_W-1:0] key_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              status_o,
  output logic [IDX_W-1:0]  found_position_o,
  output logic [CNT_W-1:0]  count_after_o
);

  ram_req_t          mem_req;
  logic [DATA_W-1:0] rdata;
  logic              done;
  res_t              res;
  res_t              res_q;
  logic              res_valid_q;
  logic              slot_free;

  assign slot_free = !res_valid_q || out_ready_i;

  olirf_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .operation_i (operation_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .key_i       (key_i),
    .mem_o       (mem_req),
    .rdata_i     (rdata),
    .slot_free_i (slot_free),
    .done_o      (done),
    .res_o       (res)
  );

  olirf_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (done) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (done) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = res_valid_q;
  assign status_o         = res_q.status;
  assign found_position_o = res_q.where;
  assign count_after_o    = res_q.count;

endmodule

/* verif/tb_ordered_list_insert_remove_find_unit.sv */
// Self-checking testbench for the ordered list insert/remove/find unit.
`timescale 1ns / 1ps
module tb_ordered_list_insert_remove_find_unit;
  import olirf_pkg::*;

  // Code with no operation behind it; the block must fail it
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Receiver hold-off used to back the block up
  localparam int HOLD_OFF_CYCLES = 300;
  // Longest sequencer pass plus margin
  localparam int TAIL_CYCLES = 2 * CAPACITY + 20;

  typedef struct {
    logic             status;
    logic [IDX_W-1:0] where;
    logic [CNT_W-1:0] count;
  } outcome_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        operation_i;
  logic [CNT_W-1:0]  position_i;
  logic [DATA_W-1:0] value_i;
  logic [DATA_W-1:0] key_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              status_o;
  logic [IDX_W-1:0]  found_position_o;
  logic [CNT_W-1:0]  count_after_o;

  // Shadow copy of the list contents and the outcomes still owed by the block
  logic [DATA_W-1:0] shadow_list[$];
  outcome_t          pending_outcomes[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int recv_hold_left = 0;

  int mismatch_count     = 0;
  int n_checked          = 0;
  int n_insert           = 0;
  int n_remove           = 0;
  int n_find             = 0;
  int n_find_hit         = 0;
  int n_unused           = 0;
  int n_failed           = 0;
  int n_full_seen        = 0;
  int input_stall_cycles = 0;

  ordered_list_insert_remove_find_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .key_i            (key_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .count_after_o    (count_after_o)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run one accepted request against the shadow list and queue its outcome
  task automatic apply_to_shadow_list(input logic [1:0] op, input logic [CNT_W-1:0] pos,
                                      input logic [DATA_W-1:0] val,
                                      input logic [DATA_W-1:0] key);
    outcome_t res;
    res.status = 1'b1;
    res.where  = '0;
    if (op == OP_INSERT) begin
      n_insert++;
      if (shadow_list.size() < CAPACITY && pos <= shadow_list.size()) begin
        shadow_list.insert(int'(pos), val);
        res.status = 1'b0;
        if (shadow_list.size() == CAPACITY) n_full_seen++;
      end
    end else if (op == OP_REMOVE) begin
      n_remove++;
      if (pos < shadow_list.size()) begin
        shadow_list.delete(int'(pos));
        res.status = 1'b0;
      end
    end else if (op == OP_FIND) begin
      n_find++;
      // first match wins
      for (int i = 0; i < shadow_list.size(); i++) begin
        if (shadow_list[i] == key) begin
          res.status = 1'b0;
          res.where  = IDX_W'(i);
          n_find_hit++;
          break;
        end
      end
    end else begin
      n_unused++;
    end
    if (res.status) n_failed++;
    res.count = CNT_W'(shadow_list.size());
    pending_outcomes.push_back(res);
  endtask

  // Offer one request, holding it until the block takes it
  task automatic send_request(input logic [1:0] op, input logic [CNT_W-1:0] pos,
                              input logic [DATA_W-1:0] val, input logic [DATA_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    position_i  <= pos;
    value_i     <= val;
    key_i       <= key;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_to_shadow_list(op, pos, val, key);
  endtask

  // Stop offering and wait for every owed result
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // Half the values from a tiny pool so that duplicates show up
  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(1)) return DATA_W'($urandom_range(7)) - DATA_W'(4);
    return $urandom;
  endfunction

  // Empty list: every request here must fail, insert at position 1 included
  task automatic test_empty_list();
    send_request(OP_REMOVE, '0, '0, '0);
    send_request(OP_FIND, '0, '0, '0);
    send_request(OP_INSERT, CNT_W'(1), 32'h1234_5678, '0);
    send_request(OP_UNUSED, '1, '1, '1);
  endtask

  // Value extremes, head/middle/tail edits, duplicates and out-of-range positions
  task automatic test_edge_cases();
    send_request(OP_INSERT, '0, 32'h8000_0000, '0);
    send_request(OP_INSERT, CNT_W'(1), 32'h7FFF_FFFF, '1);
    send_request(OP_INSERT, CNT_W'(1), 32'hFFFF_FFFF, '0);
    send_request(OP_INSERT, '0, 32'h0000_0000, '1);
    send_request(OP_INSERT, CNT_W'(4), 32'h8000_0000, '0);
    send_request(OP_FIND, '0, '0, 32'h7FFF_FFFF);
    send_request(OP_FIND, '1, '0, 32'hFFFF_FFFF);
    send_request(OP_FIND, '0, '1, 32'h0000_0000);
    send_request(OP_FIND, '0, '0, 32'h8000_0000);
    send_request(OP_FIND, '0, '0, 32'h5555_AAAA);
    send_request(OP_INSERT, '1, 32'hAAAA_5555, '0);
    send_request(OP_INSERT, CNT_W'(CAPACITY), 32'h0F0F_0F0F, '0);
    send_request(OP_INSERT, CNT_W'(6), 32'h0F0F_0F0F, '0);
    send_request(OP_REMOVE, CNT_W'(CAPACITY), '0, '0);
    send_request(OP_REMOVE, CNT_W'(5), '0, '0);
    send_request(OP_REMOVE, CNT_W'(2), '0, '0);
    send_request(OP_REMOVE, CNT_W'(3), '0, '0);
    send_request(OP_REMOVE, '0, '0, '0);
    send_request(OP_UNUSED, '0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_FIND, '0, '0, 32'hFFFF_FFFF);
  endtask

  // Fill to capacity, poke the full list, then empty it again
  task automatic test_fill_and_drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (shadow_list.size() < CAPACITY)
      send_request(OP_INSERT, CNT_W'($urandom_range(shadow_list.size())), $urandom, $urandom);
    send_request(OP_INSERT, '0, $urandom, '0);
    send_request(OP_INSERT, CNT_W'(CAPACITY), $urandom, '0);
    send_request(OP_FIND, '0, '0, shadow_list[CAPACITY-1]);
    send_request(OP_REMOVE, CNT_W'(CAPACITY), '0, '0);
    send_request(OP_REMOVE, CNT_W'(CAPACITY - 1), '0, '0);
    while (shadow_list.size() > 0)
      send_request(OP_REMOVE, CNT_W'($urandom_range(shadow_list.size() - 1)), $urandom,
                   $urandom);
  endtask

  // Hold the output off while requests keep coming, so the block backs up
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    recv_hold_left = HOLD_OFF_CYCLES;
    repeat (4) send_request(OP_INSERT, '0, pick_value(), '0);
    repeat (4) send_request(OP_FIND, '0, '0, pick_value());
    settle();
  endtask

  // Mostly well-formed edits that sweep the count between empty and full, plus noise
  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    int               goal;
    int               cnt;
    int               r;
    logic [1:0]       op;
    logic [CNT_W-1:0] pos;
    logic [DATA_W-1:0] val;
    logic [DATA_W-1:0] key;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    goal = $urandom_range(CAPACITY);
    for (int k = 0; k < n_items; k++) begin
      cnt = shadow_list.size();
      r   = $urandom_range(99);
      val = pick_value();
      key = pick_value();
      pos = CNT_W'($urandom_range(127));
      // new fill goal once reached; extremes come up often
      if (cnt == goal) begin
        case ($urandom_range(3))
          0: goal = 0;
          1: goal = CAPACITY;
          default: goal = $urandom_range(CAPACITY);
        endcase
      end
      if (r < 8) begin
        op = 2'($urandom_range(3));
      end else if (r < 40) begin
        op = OP_FIND;
        if (cnt > 0 && $urandom_range(1)) key = shadow_list[$urandom_range(cnt - 1)];
      end else if (cnt < goal || cnt == 0) begin
        op  = OP_INSERT;
        pos = CNT_W'($urandom_range(cnt));
      end else begin
        op  = OP_REMOVE;
        pos = CNT_W'($urandom_range(cnt - 1));
      end
      send_request(op, pos, val, key);
    end
  endtask

  // Long receiver hold-off: counts its cycles and the input cycles it blocks
  initial begin : receiver_hold_off
    forever begin
      @(posedge clk_i);
      if (recv_hold_left > 0) begin
        if (in_valid_i && !in_ready_o) input_stall_cycles++;
        recv_hold_left--;
      end
    end
  end

  // Result checker and receiver-side ready
  initial begin : result_checker
    outcome_t want;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        n_checked++;
        if (pending_outcomes.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no request outstanding: status %0b pos %0d count %0d",
                   $time, status_o, found_position_o, count_after_o);
        end else begin
          want = pending_outcomes.pop_front();
          if (status_o !== want.status) begin
            mismatch_count++;
            $display("%0t: status expected %0b actual %0b", $time, want.status, status_o);
          end
          if (found_position_o !== want.where) begin
            mismatch_count++;
            $display("%0t: found_position expected %0d actual %0d", $time, want.where,
                     found_position_o);
          end
          if (count_after_o !== want.count) begin
            mismatch_count++;
            $display("%0t: count_after expected %0d actual %0d", $time, want.count,
                     count_after_o);
          end
        end
      end
      if (recv_hold_left > 0) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus sequence
  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    operation_i <= OP_INSERT;
    position_i  <= '0;
    value_i     <= '0;
    key_i       <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_edge_cases();
    test_fill_and_drain();
    test_output_backpressure();
    test_random_traffic(380, 0, 0);
    test_random_traffic(370, 63, 0);
    test_random_traffic(370, 0, 63);
    test_random_traffic(370, 12, 12);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Checked %0d results: %0d inserts, %0d removes, %0d finds (%0d hits), %0d unused",
             n_checked, n_insert, n_remove, n_find, n_find_hit, n_unused);
    $display("%0d requests failed, list full %0d times, input held off %0d cycles",
             n_failed, n_full_seen, input_stall_cycles);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* ordered_list_insert_remove_find_unit.f */
design/olirf_pkg.sv
design/olirf_ram.sv
design/olirf_seq.sv
design/ordered_list_insert_remove_find_unit.sv
verif/tb_ordered_list_insert_remove_find_unit.sv
